// ----- sv/vis_pkg.sv -----
// Shared types and constants for the Verlet integrator with sleep handling.
package vis_pkg;

    // Position-format word width (signed fixed point) and counter width
    localparam int POS_W  = 32;
    localparam int CNT_W  = 16;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_GRAV_X       = 3'd0;
    localparam logic [CFG_AW-1:0] REG_GRAV_Y       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DAMPING      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DT_SQ        = 3'd3;
    localparam logic [CFG_AW-1:0] REG_INV_DT       = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SLEEP_SPD_SQ = 3'd5;
    localparam logic [CFG_AW-1:0] REG_WAKE_THR_SQ  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SLEEP_FRAMES = 3'd7;

    // Edges from the accepting edge to the edge that takes its result
    localparam int LATENCY = 6;

    // One body record going in
    typedef struct packed {
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic signed [POS_W-1:0] old_x;
        logic signed [POS_W-1:0] old_y;
        logic signed [POS_W-1:0] acc_x;
        logic signed [POS_W-1:0] acc_y;
        logic                    asleep_in;
        logic [CNT_W-1:0]        still_count_in;
    } t_body_in;

    // One updated body record coming out
    typedef struct packed {
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
        logic signed [POS_W-1:0] prev_x;
        logic signed [POS_W-1:0] prev_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic                    asleep_out;
        logic [CNT_W-1:0]        still_count_out;
    } t_body_out;

endpackage

// ----- sv/verlet_integrate_with_sleep_core.sv -----
// Pipelined 2D position-Verlet body update with sleep / wake handling.
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with i_start high
//   and o_busy low; i_item carries one body record. o_busy is high only from
//   reset until the first edge after reset is released.
//   Result channel: o_done strobes for one cycle with the updated record on
//   o_result. The receiver cannot stall, so the pipeline never holds.
//   Config: i_cfg_we writes i_cfg_wdata into register i_cfg_addr at the edge;
//   write only while no transaction is in flight.
// Timing:
//   The record passes the stage registers A to E and then the result register, which
//   drives o_done and o_result; one body is taken every cycle. The depth is set by the
//   multiplier chain: velocity product, then velocity squared, then the
//   threshold compares.
//   Stages: A diffs/magnitudes, B products, C saturate/round,
//   D velocity squares and position sum, E sums and clamp, F sleep decision.
// Reset:
//   Clears all stage valid bits and loads the default register values.
module verlet_integrate_with_sleep_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  vis_pkg::t_body_in           i_item,
    input  logic                        i_cfg_we,
    input  logic [vis_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [vis_pkg::CFG_DW-1:0]  i_cfg_wdata,
    output logic                        o_done,
    output vis_pkg::t_body_out          o_result
);

    localparam int W        = vis_pkg::POS_W;
    localparam int CW       = vis_pkg::CNT_W;
    localparam int PW       = W + 17;             // magnitude times Q0.16 / integer
    localparam int SW       = W + 3;              // three-term position sum
    localparam int SQ_W     = 50;                 // scaled square, capped at 2^49
    localparam int SPD_W    = SQ_W + 1;           // sum of two scaled squares
    localparam int SQ_SHIFT = 32 - 2 * FRAC_BITS;

    localparam logic [63:0]       SQ_LIM  = 64'(1) << (49 - SQ_SHIFT);
    localparam logic [SQ_W-1:0]   SQ_CAP  = SQ_W'(64'(1) << 49);
    localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] POS_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0]     VP_MAX  = PW'({(W-1){1'b1}});
    localparam logic [PW-1:0]     VN_MAX  = PW'(1) << (W - 1);
    localparam logic [PW-1:0]     RND     = PW'(1) << 15;
    localparam logic signed [SW-1:0] S_MAX = SW'(POS_MAX);
    localparam logic signed [SW-1:0] S_MIN = SW'(POS_MIN);
    localparam logic signed [W-1:0] GRAV_Y_RST = W'(-(64'sd200 <<< FRAC_BITS));

    // Square in 2^-32 units, capped
    function automatic logic [SQ_W-1:0] sq_scale(input logic big, input logic [63:0] p);
        if (big || p > SQ_LIM) begin
            return SQ_CAP;
        end
        return SQ_W'(p << SQ_SHIFT);
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [W-1:0] r_grav [2];
    logic [15:0]         r_damping;
    logic [15:0]         r_dt_sq;
    logic [15:0]         r_inv_dt;
    logic [31:0]         r_sleep_spd;
    logic [31:0]         r_wake_thr;
    logic [CW-1:0]       r_sleep_frames;
    logic                r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0]      <= '0;
            r_grav[1]      <= GRAV_Y_RST;
            r_damping      <= 16'd64880;
            r_dt_sq        <= 16'd18;
            r_inv_dt       <= 16'd60;
            r_sleep_spd    <= '0;
            r_wake_thr     <= '0;
            r_sleep_frames <= CW'(60);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vis_pkg::REG_GRAV_X:       r_grav[0]      <= signed'(i_cfg_wdata[W-1:0]);
                vis_pkg::REG_GRAV_Y:       r_grav[1]      <= signed'(i_cfg_wdata[W-1:0]);
                vis_pkg::REG_DAMPING:      r_damping      <= i_cfg_wdata[15:0];
                vis_pkg::REG_DT_SQ:        r_dt_sq        <= i_cfg_wdata[15:0];
                vis_pkg::REG_INV_DT:       r_inv_dt       <= i_cfg_wdata[15:0];
                vis_pkg::REG_SLEEP_SPD_SQ: r_sleep_spd    <= i_cfg_wdata[31:0];
                vis_pkg::REG_WAKE_THR_SQ:  r_wake_thr     <= i_cfg_wdata[31:0];
                vis_pkg::REG_SLEEP_FRAMES: r_sleep_frames <= i_cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // Busy only while coming out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;

    logic w_accept;
    assign w_accept = i_start && !r_busy;

    // ---------------------------------------------------------------
    // Stage A: differences, gravity sum and magnitudes
    // ---------------------------------------------------------------
    logic signed [W-1:0] w_cur [2];
    logic signed [W-1:0] w_old [2];
    logic signed [W-1:0] w_acc [2];
    logic signed [W:0]   w_d   [2];
    logic signed [W:0]   w_g   [2];

    assign w_cur[0] = i_item.cur_x;
    assign w_cur[1] = i_item.cur_y;
    assign w_old[0] = i_item.old_x;
    assign w_old[1] = i_item.old_y;
    assign w_acc[0] = i_item.acc_x;
    assign w_acc[1] = i_item.acc_y;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_d[k] = (W+1)'(w_cur[k]) - (W+1)'(w_old[k]);
            w_g[k] = (W+1)'(w_acc[k]) + (W+1)'(r_grav[k]);
        end
    end

    logic                r_a_v;
    logic signed [W-1:0] r_a_cur  [2];
    logic signed [W-1:0] r_a_old  [2];
    logic                r_a_dneg [2];
    logic [W:0]          r_a_dmag [2];
    logic                r_a_gneg [2];
    logic [W:0]          r_a_gmag [2];
    logic [W-1:0]        r_a_amag [2];
    logic                r_a_asleep;
    logic [CW-1:0]       r_a_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_a_cur[k]  <= w_cur[k];
            r_a_old[k]  <= w_old[k];
            r_a_dneg[k] <= w_d[k][W];
            r_a_dmag[k] <= w_d[k][W] ? (W+1)'(-w_d[k]) : (W+1)'(w_d[k]);
            r_a_gneg[k] <= w_g[k][W];
            r_a_gmag[k] <= w_g[k][W] ? (W+1)'(-w_g[k]) : (W+1)'(w_g[k]);
            r_a_amag[k] <= w_acc[k][W-1] ? W'(-w_acc[k]) : W'(w_acc[k]);
        end
        r_a_asleep <= i_item.asleep_in;
        r_a_count  <= i_item.still_count_in;
    end

    // ---------------------------------------------------------------
    // Stage B: products
    // ---------------------------------------------------------------
    logic [63:0] w_a_am64 [2];
    logic [31:0] w_a_amlo [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_a_am64[k] = 64'(r_a_amag[k]);
            w_a_amlo[k] = w_a_am64[k][31:0];
        end
    end

    logic                r_b_v;
    logic signed [W-1:0] r_b_cur   [2];
    logic signed [W-1:0] r_b_old   [2];
    logic                r_b_dneg  [2];
    logic                r_b_gneg  [2];
    logic [PW-1:0]       r_b_vprod [2];
    logic [PW-1:0]       r_b_dprod [2];
    logic [PW-1:0]       r_b_gprod [2];
    logic                r_b_abig  [2];
    logic [63:0]         r_b_asq   [2];
    logic                r_b_asleep;
    logic [CW-1:0]       r_b_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_b_cur[k]   <= r_a_cur[k];
            r_b_old[k]   <= r_a_old[k];
            r_b_dneg[k]  <= r_a_dneg[k];
            r_b_gneg[k]  <= r_a_gneg[k];
            r_b_vprod[k] <= PW'(r_a_dmag[k]) * PW'(r_inv_dt);
            r_b_dprod[k] <= PW'(r_a_dmag[k]) * PW'(r_damping);
            r_b_gprod[k] <= PW'(r_a_gmag[k]) * PW'(r_dt_sq);
            r_b_abig[k]  <= |w_a_am64[k][63:32];
            r_b_asq[k]   <= 64'(w_a_amlo[k]) * 64'(w_a_amlo[k]);
        end
        r_b_asleep <= r_a_asleep;
        r_b_count  <= r_a_count;
    end

    // ---------------------------------------------------------------
    // Stage C: velocity saturation, rounding, acceleration square sum
    // ---------------------------------------------------------------
    logic signed [W-1:0] w_b_vel  [2];
    logic [W-1:0]        w_b_vmag [2];
    logic [PW-1:0]       w_b_drnd [2];
    logic [PW-1:0]       w_b_grnd [2];
    logic [W:0]          w_b_dr   [2];
    logic [W:0]          w_b_gr   [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (r_b_dneg[k]) begin
                if (r_b_vprod[k] > VN_MAX) begin
                    w_b_vel[k]  = POS_MIN;
                    w_b_vmag[k] = W'(VN_MAX);
                end else begin
                    w_b_vel[k]  = W'(-r_b_vprod[k]);
                    w_b_vmag[k] = W'(r_b_vprod[k]);
                end
            end else begin
                if (r_b_vprod[k] > VP_MAX) begin
                    w_b_vel[k]  = POS_MAX;
                    w_b_vmag[k] = W'(VP_MAX);
                end else begin
                    w_b_vel[k]  = W'(r_b_vprod[k]);
                    w_b_vmag[k] = W'(r_b_vprod[k]);
                end
            end
            // round to nearest, ties away from zero (on the magnitude)
            w_b_drnd[k] = r_b_dprod[k] + RND;
            w_b_grnd[k] = r_b_gprod[k] + RND;
            w_b_dr[k]   = w_b_drnd[k][W+16:16];
            w_b_gr[k]   = w_b_grnd[k][W+16:16];
        end
    end

    logic                r_c_v;
    logic signed [W-1:0] r_c_cur  [2];
    logic signed [W-1:0] r_c_old  [2];
    logic signed [W-1:0] r_c_vel  [2];
    logic [W-1:0]        r_c_vmag [2];
    logic signed [W+1:0] r_c_dterm [2];
    logic signed [W+1:0] r_c_gterm [2];
    logic [SPD_W-1:0]    r_c_accsq;
    logic                r_c_asleep;
    logic [CW-1:0]       r_c_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_c_cur[k]   <= r_b_cur[k];
            r_c_old[k]   <= r_b_old[k];
            r_c_vel[k]   <= w_b_vel[k];
            r_c_vmag[k]  <= w_b_vmag[k];
            r_c_dterm[k] <= r_b_dneg[k] ? -signed'((W+2)'(w_b_dr[k]))
                                        :  signed'((W+2)'(w_b_dr[k]));
            r_c_gterm[k] <= r_b_gneg[k] ? -signed'((W+2)'(w_b_gr[k]))
                                        :  signed'((W+2)'(w_b_gr[k]));
        end
        r_c_accsq  <= SPD_W'(sq_scale(r_b_abig[0], r_b_asq[0]))
                    + SPD_W'(sq_scale(r_b_abig[1], r_b_asq[1]));
        r_c_asleep <= r_b_asleep;
        r_c_count  <= r_b_count;
    end

    // ---------------------------------------------------------------
    // Stage D: velocity squares and Verlet position sum
    // ---------------------------------------------------------------
    logic [63:0] w_c_vm64 [2];
    logic [31:0] w_c_vmlo [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_c_vm64[k] = 64'(r_c_vmag[k]);
            w_c_vmlo[k] = w_c_vm64[k][31:0];
        end
    end

    logic                 r_d_v;
    logic signed [W-1:0]  r_d_cur [2];
    logic signed [W-1:0]  r_d_old [2];
    logic signed [W-1:0]  r_d_vel [2];
    logic                 r_d_vbig [2];
    logic [63:0]          r_d_vsq [2];
    logic signed [SW-1:0] r_d_sum [2];
    logic [SPD_W-1:0]     r_d_accsq;
    logic                 r_d_asleep;
    logic [CW-1:0]        r_d_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_d_cur[k]  <= r_c_cur[k];
            r_d_old[k]  <= r_c_old[k];
            r_d_vel[k]  <= r_c_vel[k];
            r_d_vbig[k] <= |w_c_vm64[k][63:32];
            r_d_vsq[k]  <= 64'(w_c_vmlo[k]) * 64'(w_c_vmlo[k]);
            r_d_sum[k]  <= SW'(r_c_cur[k]) + SW'(r_c_dterm[k]) + SW'(r_c_gterm[k]);
        end
        r_d_accsq  <= r_c_accsq;
        r_d_asleep <= r_c_asleep;
        r_d_count  <= r_c_count;
    end

    // ---------------------------------------------------------------
    // Stage E: speed sum and position clamp
    // ---------------------------------------------------------------
    logic                r_e_v;
    logic signed [W-1:0] r_e_cur [2];
    logic signed [W-1:0] r_e_old [2];
    logic signed [W-1:0] r_e_vel [2];
    logic signed [W-1:0] r_e_new [2];
    logic [SPD_W-1:0]    r_e_spd;
    logic [SPD_W-1:0]    r_e_accsq;
    logic                r_e_asleep;
    logic [CW-1:0]       r_e_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_e_cur[k] <= r_d_cur[k];
            r_e_old[k] <= r_d_old[k];
            r_e_vel[k] <= r_d_vel[k];
            if (r_d_sum[k] > S_MAX) begin
                r_e_new[k] <= POS_MAX;
            end else if (r_d_sum[k] < S_MIN) begin
                r_e_new[k] <= POS_MIN;
            end else begin
                r_e_new[k] <= W'(r_d_sum[k]);
            end
        end
        r_e_spd    <= SPD_W'(sq_scale(r_d_vbig[0], r_d_vsq[0]))
                    + SPD_W'(sq_scale(r_d_vbig[1], r_d_vsq[1]));
        r_e_accsq  <= r_d_accsq;
        r_e_asleep <= r_d_asleep;
        r_e_count  <= r_d_count;
    end

    // ---------------------------------------------------------------
    // Stage F: sleep / wake decision and result register
    // ---------------------------------------------------------------
    logic [SPD_W-1:0]    w_wake;
    logic [SPD_W-1:0]    w_sleep;
    logic [CW-1:0]       w_cnt_inc;
    logic                w_integ;
    logic                w_asleep;
    logic [CW-1:0]       w_count;
    logic                w_zero_vel;

    assign w_wake    = SPD_W'({r_wake_thr, 16'b0});
    assign w_sleep   = SPD_W'({r_sleep_spd, 16'b0});
    assign w_cnt_inc = (&r_e_count) ? r_e_count : r_e_count + CW'(1);

    always_comb begin
        w_integ    = 1'b1;
        w_asleep   = r_e_asleep;
        w_count    = r_e_count;
        w_zero_vel = 1'b0;
        if (r_e_asleep) begin
            if (r_e_spd > w_wake || r_e_accsq > w_wake) begin
                w_asleep = 1'b0;
                w_count  = '0;
            end else begin
                w_integ = 1'b0;
            end
        end else if (r_e_spd < w_sleep) begin
            w_count = w_cnt_inc;
            if (w_cnt_inc >= r_sleep_frames) begin
                w_asleep   = 1'b1;
                w_zero_vel = 1'b1;
                w_integ    = 1'b0;
            end
        end else begin
            w_count = '0;
        end
    end

    logic                r_done;
    vis_pkg::t_body_out  r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.new_x           <= w_integ ? r_e_new[0] : r_e_cur[0];
        r_result.new_y           <= w_integ ? r_e_new[1] : r_e_cur[1];
        r_result.prev_x          <= w_integ ? r_e_cur[0] : r_e_old[0];
        r_result.prev_y          <= w_integ ? r_e_cur[1] : r_e_old[1];
        r_result.vel_x           <= w_zero_vel ? '0 : r_e_vel[0];
        r_result.vel_y           <= w_zero_vel ? '0 : r_e_vel[1];
        r_result.asleep_out      <= w_asleep;
        r_result.still_count_out <= w_count;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- sv/vis_checker.sv -----
// Port-level checker for the Verlet integrator core, with its bind.
module vis_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input vis_pkg::t_body_in           i_item,
    input logic                        o_done,
    input vis_pkg::t_body_out          o_result
);

    localparam int LAT  = vis_pkg::LATENCY;
    localparam int RUNW = $clog2(LAT + 1);

    // Cycles since reset release, saturating at the pipeline latency
    logic [RUNW-1:0] r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (r_run != RUNW'(LAT)) begin
            r_run <= r_run + RUNW'(1);
        end
    end

    logic w_warm;
    assign w_warm = (r_run == RUNW'(LAT));

    // Every accepted transaction yields one result strobe, and every strobe has an accepted transaction
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_warm |-> (o_done == $past(i_start && !o_busy, LAT)))
        else $error("result strobe does not match accepted transaction");

    // An awake result always took the Verlet step: previous is old current
    a_awake_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_warm && o_done && !o_result.asleep_out) |->
        (o_result.prev_x == $past(i_item.cur_x, LAT) &&
         o_result.prev_y == $past(i_item.cur_y, LAT)))
        else $error("awake body did not shift current into previous");

    // A body staying asleep keeps position and count
    a_stay_asleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_warm && o_done && o_result.asleep_out && $past(i_item.asleep_in, LAT)) |->
        (o_result.new_x == $past(i_item.cur_x, LAT) &&
         o_result.new_y == $past(i_item.cur_y, LAT) &&
         o_result.prev_x == $past(i_item.old_x, LAT) &&
         o_result.still_count_out == $past(i_item.still_count_in, LAT)))
        else $error("sleeping body moved or changed its count");

    // A body falling asleep reports zero velocity
    a_fall_asleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_warm && o_done && o_result.asleep_out && !$past(i_item.asleep_in, LAT)) |->
        (o_result.vel_x == '0 && o_result.vel_y == '0 &&
         o_result.new_x == $past(i_item.cur_x, LAT)))
        else $error("body fell asleep with nonzero velocity or moved");

endmodule

bind verlet_integrate_with_sleep_core vis_checker u_vis_checker (.*);
